@@ design/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// clr_pkg: shared types and codes of the clipped line rasterizer
// Holds the line state record, the item mode codes and the register indexes.
// ----------------------------------------------------------------------------
package clr_pkg;

  // Width of the configuration register index
  localparam int unsigned CfgIdxW = 3;

  // Item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_HEIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_X     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_Y     = 3'd5;

  // Line walker state: next pixel, end of the major axis, deltas, direction
  typedef struct packed {
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] major_end;
    logic [15:0]        delta_major;
    logic [15:0]        delta_minor;
    logic               x_major;
    logic               minor_down;
  } line_t;

endpackage

@@ design/clr_line_setup.sv @@
// ----------------------------------------------------------------------------
// clr_line_setup: endpoint translation and line setup
// Offsets both endpoints, picks the major axis, orders the endpoints so the
// major coordinate runs upward and derives the absolute deltas.
// ----------------------------------------------------------------------------
module clr_line_setup (
  input  logic signed [14:0] start_x_i,
  input  logic signed [14:0] start_y_i,
  input  logic signed [14:0] end_x_i,
  input  logic signed [14:0] end_y_i,
  input  logic signed [14:0] shift_x_i,
  input  logic signed [14:0] shift_y_i,
  output clr_pkg::line_t     line_o
);

  logic signed [15:0] x1, y1, x2, y2;
  logic signed [16:0] dx_s, dy_s;
  logic [15:0]        dx, dy;
  logic               x_major, swap;
  logic signed [15:0] ax, ay, bx, by;

  // Translate endpoints
  assign x1 = {start_x_i[14], start_x_i} + {shift_x_i[14], shift_x_i};
  assign y1 = {start_y_i[14], start_y_i} + {shift_y_i[14], shift_y_i};
  assign x2 = {end_x_i[14], end_x_i} + {shift_x_i[14], shift_x_i};
  assign y2 = {end_y_i[14], end_y_i} + {shift_y_i[14], shift_y_i};

  // Absolute deltas
  assign dx_s = {x2[15], x2} - {x1[15], x1};
  assign dy_s = {y2[15], y2} - {y1[15], y1};
  assign dx   = dx_s[16] ? 16'(-dx_s) : dx_s[15:0];
  assign dy   = dy_s[16] ? 16'(-dy_s) : dy_s[15:0];

  // Ties go y-major; order endpoints upward along the major axis
  assign x_major = dx > dy;
  assign swap    = x_major ? (x1 > x2) : (y1 > y2);
  assign ax      = swap ? x2 : x1;
  assign ay      = swap ? y2 : y1;
  assign bx      = swap ? x1 : x2;
  assign by      = swap ? y1 : y2;

  always_comb begin
    line_o.cur_x       = ax;
    line_o.cur_y       = ay;
    line_o.x_major     = x_major;
    line_o.major_end   = x_major ? bx : by;
    line_o.delta_major = x_major ? dx : dy;
    line_o.delta_minor = x_major ? dy : dx;
    line_o.minor_down  = x_major ? !(ay < by) : !(ax < bx);
  end

endmodule

@@ design/clipped_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// clipped_line_rasterizer: Bresenham line walker with offset and clip flag
// Load items start a line and emit its first pixel; advance items emit the
// next pixel of the line in progress.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns one result per item. An accepted item is set up (endpoint offset,
// axis choice, deltas) into the input register; once the output register can
// take a result, one Bresenham step of the shared line state produces the
// result into the output register. Back-to-back items stream at one per clock
// as long as the consumer keeps ready high. The offsets are applied when a load
// item is accepted and the clip registers are read for every pixel; change them
// only while the block is idle. An advance with no line in progress returns a
// result with valid_res low and all other fields zero.
module clipped_line_rasterizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic signed [14:0]            start_x_i,
  input  logic signed [14:0]            start_y_i,
  input  logic signed [14:0]            end_x_i,
  input  logic signed [14:0]            end_y_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            pixel_x_o,
  output logic signed [15:0]            pixel_y_o,
  output logic                          inside_res_o,
  output logic                          valid_res_o,
  output logic                          last_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [clr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [14:0]                   cfg_data_i
);

  // Configuration registers
  logic [14:0]        clip_left_q, clip_top_q, clip_width_q, clip_height_q;
  logic signed [14:0] shift_x_q, shift_y_q;

  // Input stage
  logic               in_valid_q;
  logic               in_mode_q;
  clr_pkg::line_t     in_line_q;
  clr_pkg::line_t     setup_line;

  // Line state
  logic               active_q, active_d;
  clr_pkg::line_t     line_q, line_d;
  logic signed [17:0] err_q, err_d;

  // Output stage
  logic               out_valid_q;
  logic signed [15:0] pix_x_q, pix_y_q;
  logic               inside_q, vres_q, last_q;
  logic signed [15:0] pix_x_d, pix_y_d;
  logic               inside_d, vres_d, last_d;

  // Step datapath
  logic               proc;
  logic               is_load, live, fin, take;
  clr_pkg::line_t     ln;
  logic signed [17:0] err_cur, err_sum;
  logic signed [18:0] two_err;
  logic signed [15:0] major_cur, minor_cur, minor_next;
  logic [15:0]        right_edge, bottom_edge;
  logic               in_clip;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_width_q  <= '0;
      clip_height_q <= '0;
      shift_x_q     <= '0;
      shift_y_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        clr_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i;
        clr_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i;
        clr_pkg::CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i;
        clr_pkg::CFG_CLIP_HEIGHT: clip_height_q <= cfg_data_i;
        clr_pkg::CFG_SHIFT_X:     shift_x_q     <= cfg_data_i;
        clr_pkg::CFG_SHIFT_Y:     shift_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Set up the line from the raw endpoints on the way in
  clr_line_setup u_setup (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .shift_x_i (shift_x_q),
    .shift_y_i (shift_y_q),
    .line_o    (setup_line)
  );

  // Advance the input stage whenever the output stage can take a result
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_mode_q <= mode_i;
      in_line_q <= setup_line;
    end
  end

  // Pick the line to step: a fresh load or the line in progress
  assign is_load = (in_mode_q == clr_pkg::MODE_LOAD);
  assign ln      = is_load ? in_line_q : line_q;
  assign err_cur = is_load ? '0 : err_q;
  assign live    = is_load || active_q;

  // Final pixel when the major coordinate reaches its end
  assign major_cur = ln.x_major ? ln.cur_x : ln.cur_y;
  assign minor_cur = ln.x_major ? ln.cur_y : ln.cur_x;
  assign fin       = major_cur >= ln.major_end;

  // Clip test against left+width and top+height without wrap
  assign right_edge  = {1'b0, clip_left_q} + {1'b0, clip_width_q};
  assign bottom_edge = {1'b0, clip_top_q} + {1'b0, clip_height_q};
  assign in_clip = ($signed({ln.cur_x[15], ln.cur_x}) >= $signed({2'b00, clip_left_q}))
                && ($signed({ln.cur_y[15], ln.cur_y}) >= $signed({2'b00, clip_top_q}))
                && ($signed({ln.cur_x[15], ln.cur_x}) <  $signed({1'b0, right_edge}))
                && ($signed({ln.cur_y[15], ln.cur_y}) <  $signed({1'b0, bottom_edge}));

  // Bresenham error update and minor-axis step
  assign err_sum    = err_cur + $signed({2'b00, ln.delta_minor});
  assign two_err    = {err_sum, 1'b0};
  assign take       = two_err >= $signed({3'b000, ln.delta_major});
  assign minor_next = take ? (ln.minor_down ? minor_cur - 16'sd1 : minor_cur + 16'sd1)
                           : minor_cur;

  always_comb begin
    line_d = ln;
    if (ln.x_major) begin
      line_d.cur_x = ln.cur_x + 16'sd1;
      line_d.cur_y = minor_next;
    end else begin
      line_d.cur_y = ln.cur_y + 16'sd1;
      line_d.cur_x = minor_next;
    end
    err_d    = take ? err_sum - $signed({2'b00, ln.delta_major}) : err_sum;
    active_d = live ? !fin : active_q;
  end

  // Result fields; an advance with no line gives an all-zero beat
  always_comb begin
    pix_x_d  = live ? ln.cur_x : '0;
    pix_y_d  = live ? ln.cur_y : '0;
    inside_d = live && in_clip;
    vres_d   = live;
    last_d   = live && fin;
  end

  // Update line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (proc) begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && live) begin
      line_q <= line_d;
      err_q  <= err_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      pix_x_q  <= pix_x_d;
      pix_y_q  <= pix_y_d;
      inside_q <= inside_d;
      vres_q   <= vres_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign inside_res_o = inside_q;
  assign valid_res_o  = vres_q;
  assign last_o       = last_q;

`ifndef SYNTH
  // An empty beat carries all-zero fields
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |->
      pixel_x_o == 16'sd0 && pixel_y_o == 16'sd0 && !inside_res_o && !last_o)
    else $error("empty result beat has nonzero fields");

  // A load always yields a pixel
  a_load_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && is_load |=> out_valid_o && valid_res_o)
    else $error("load item produced no pixel");

  // The final pixel ends the line
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && last_d |=> !active_q)
    else $error("line still active after its last pixel");

  // The walker never passes the end of the major axis
  a_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |->
      (line_q.x_major ? line_q.cur_x : line_q.cur_y) <= line_q.major_end)
    else $error("major coordinate beyond line end");
`endif

endmodule
